// ----- rtl/cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// cbm_pkg
// Types and constants shared by the cartridge bank mapper and its channels.
// ----------------------------------------------------------------------------
package cbm_pkg;

    // Kind of input word.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Register select, CPU address bits 15:12.
    localparam logic [3:0] SEL_LATCH0  = 4'h8;
    localparam logic [3:0] SEL_LATCH1  = 4'h9;
    localparam logic [3:0] SEL_LATCH2  = 4'hA;
    localparam logic [3:0] SEL_LATCH3  = 4'hB;
    localparam logic [3:0] SEL_CONTROL = 4'hC;
    localparam logic [3:0] SEL_ACK     = 4'hD;
    localparam logic [3:0] SEL_PRG_SEL = 4'hE;
    localparam logic [3:0] SEL_BANK    = 4'hF;

    // Region of a bank write, CPU address bits 11:10.
    localparam logic [1:0] REGION_PRG_HI = 2'b00;
    localparam logic [1:0] REGION_MIRROR = 2'b10;
    localparam logic [1:0] REGION_CHR    = 2'b11;

    localparam logic [15:0] COUNT_LAST = 16'hFFFF;
    localparam int          PRG_REGS   = 4;
    localparam int          CHR_REGS   = 8;

    typedef struct packed {
        logic        opcode;
        logic [15:0] cpu_address;
        logic [7:0]  write_data;
    } in_word_t;

    typedef struct packed {
        logic        irq_pending;
        logic [4:0]  prg_bank_8000;
        logic [4:0]  prg_bank_a000;
        logic [4:0]  prg_bank_c000;
        logic        mirror_vertical;
        logic [31:0] chr_banks_lower;
        logic [31:0] chr_banks_upper;
    } out_word_t;

endpackage

// ----- rtl/cbm_in_if.sv -----
// ----------------------------------------------------------------------------
// cbm_in_if
// Valid/ready channel that carries CPU write and tick words into the mapper.
// ----------------------------------------------------------------------------
interface cbm_in_if;
    logic              valid;
    logic              ready;
    cbm_pkg::in_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/cbm_out_if.sv -----
// ----------------------------------------------------------------------------
// cbm_out_if
// Valid/ready channel that carries the mapping and IRQ state out of the mapper.
// ----------------------------------------------------------------------------
interface cbm_out_if;
    logic               valid;
    logic               ready;
    cbm_pkg::out_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/cartridge_bank_mapper_irq.sv -----
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq
// Cartridge bank mapper with a 16-bit up-counting CPU-cycle IRQ timer.
// ----------------------------------------------------------------------------
// Usage:
// The item channel takes one word per CPU event: either a CPU write
// (address and data) or a single CPU-cycle tick. For every word taken the
// result channel gives exactly one word holding the IRQ line and the PRG,
// mirroring and CHR mapping as they stand after that event.
// A word taken lands in the input register, is decoded against the mapper
// state and is loaded into the result register once that register is empty
// or its word is being taken, which offers its result word. One word per
// clock is sustained while the receiver takes every result word; the figure
// is set by the single decode stage between the two registers.
// When the receiver stalls, the result word holds and the input register
// holds its word, so the item channel drops ready only while both are full
// and the receiver is not taking the result.
// Reset clears all mapper registers, the timer and the IRQ line, selects
// horizontal mirroring and empties both registers.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_irq (
    input  logic          clk,
    input  logic          rst_n,
    cbm_in_if.sink        item,
    cbm_out_if.source     result
);

    logic               in_valid_reg;
    cbm_pkg::in_word_t  in_word_reg;
    logic               out_valid_reg;
    cbm_pkg::out_word_t out_word_reg;
    logic               advance;

    logic [15:0] reload_latch_reg, reload_latch_next;
    logic [15:0] irq_count_reg, irq_count_next;
    logic [2:0]  irq_control_reg, irq_control_next;
    logic        irq_line_reg, irq_line_next;
    logic [3:0]  prg_select_reg, prg_select_next;
    logic [4:0]  prg_bank_reg [cbm_pkg::PRG_REGS];
    logic [4:0]  prg_bank_next [cbm_pkg::PRG_REGS];
    logic [7:0]  chr_bank_reg [cbm_pkg::CHR_REGS];
    logic [7:0]  chr_bank_next [cbm_pkg::CHR_REGS];
    logic        mirror_reg, mirror_next;

    logic [3:0]  sel;
    logic [11:0] offset;
    logic [3:0]  nibble;
    logic [1:0]  prg_low_index;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    assign sel           = in_word_reg.cpu_address[15:12];
    assign offset        = in_word_reg.cpu_address[11:0];
    assign nibble        = in_word_reg.write_data[3:0];
    assign prg_low_index = prg_select_reg[1:0] - 2'd1;

    always_comb
    begin
        reload_latch_next = reload_latch_reg;
        irq_count_next    = irq_count_reg;
        irq_control_next  = irq_control_reg;
        irq_line_next     = irq_line_reg;
        prg_select_next   = prg_select_reg;
        prg_bank_next     = prg_bank_reg;
        chr_bank_next     = chr_bank_reg;
        mirror_next       = mirror_reg;

        if (in_word_reg.opcode == cbm_pkg::OP_TICK)
        begin
            if (irq_control_reg[1])
            begin
                if (irq_count_reg == cbm_pkg::COUNT_LAST)
                begin
                    irq_count_next = reload_latch_reg;
                    irq_line_next  = 1'b1;
                end
                else
                begin
                    irq_count_next = irq_count_reg + 16'd1;
                end
            end
        end
        else
        begin
            unique case (sel) inside
                cbm_pkg::SEL_LATCH0, cbm_pkg::SEL_LATCH1,
                cbm_pkg::SEL_LATCH2, cbm_pkg::SEL_LATCH3:
                begin
                    reload_latch_next[sel[1:0]*4 +: 4] = nibble;
                end
                cbm_pkg::SEL_CONTROL:
                begin
                    irq_control_next = in_word_reg.write_data[2:0];
                    if (in_word_reg.write_data[1])
                    begin
                        irq_count_next = reload_latch_reg;
                    end
                    irq_line_next = 1'b0;
                end
                cbm_pkg::SEL_ACK:
                begin
                    // The acknowledge restores the enable from its saved copy.
                    irq_control_next[1] = irq_control_reg[0];
                    irq_line_next       = 1'b0;
                end
                cbm_pkg::SEL_PRG_SEL:
                begin
                    prg_select_next = nibble;
                end
                cbm_pkg::SEL_BANK:
                begin
                    if (prg_select_reg >= 4'd1 && prg_select_reg <= 4'd4)
                    begin
                        prg_bank_next[prg_low_index][3:0] = nibble;
                    end
                    unique case (offset[11:10])
                        cbm_pkg::REGION_PRG_HI:
                        begin
                            prg_bank_next[offset[1:0]][4] = in_word_reg.write_data[4];
                        end
                        cbm_pkg::REGION_MIRROR:
                        begin
                            mirror_next = in_word_reg.write_data[0];
                        end
                        cbm_pkg::REGION_CHR:
                        begin
                            chr_bank_next[offset[2:0]] = in_word_reg.write_data;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                    // Writes below the cartridge ROM range change nothing.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            reload_latch_reg <= '0;
            irq_count_reg    <= '0;
            irq_control_reg  <= '0;
            irq_line_reg     <= 1'b0;
            prg_select_reg   <= '0;
            mirror_reg       <= 1'b0;
            for (int i = 0; i < cbm_pkg::PRG_REGS; i++)
            begin
                prg_bank_reg[i] <= '0;
            end
            for (int i = 0; i < cbm_pkg::CHR_REGS; i++)
            begin
                chr_bank_reg[i] <= '0;
            end
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                reload_latch_reg <= reload_latch_next;
                irq_count_reg    <= irq_count_next;
                irq_control_reg  <= irq_control_next;
                irq_line_reg     <= irq_line_next;
                prg_select_reg   <= prg_select_next;
                mirror_reg       <= mirror_next;
                prg_bank_reg     <= prg_bank_next;
                chr_bank_reg     <= chr_bank_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_word_reg <= item.payload;
        end
        if (advance)
        begin
            out_word_reg.irq_pending     <= irq_line_next;
            out_word_reg.prg_bank_8000   <= prg_bank_next[0];
            out_word_reg.prg_bank_a000   <= prg_bank_next[1];
            out_word_reg.prg_bank_c000   <= prg_bank_next[2];
            out_word_reg.mirror_vertical <= mirror_next;
            out_word_reg.chr_banks_lower <= {chr_bank_next[3], chr_bank_next[2],
                                             chr_bank_next[1], chr_bank_next[0]};
            out_word_reg.chr_banks_upper <= {chr_bank_next[7], chr_bank_next[6],
                                             chr_bank_next[5], chr_bank_next[4]};
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_word_reg;

    // A control or acknowledge write always drops the IRQ line.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_word_reg.opcode == cbm_pkg::OP_WRITE
            && (sel == cbm_pkg::SEL_CONTROL || sel == cbm_pkg::SEL_ACK)
        |=> !irq_line_reg && !result.payload.irq_pending)
        else $error("IRQ line not cleared by control or acknowledge write");

    // An enabled tick at the last count reloads the counter and raises the IRQ.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_word_reg.opcode == cbm_pkg::OP_TICK && irq_control_reg[1]
            && irq_count_reg == cbm_pkg::COUNT_LAST
        |=> irq_line_reg && irq_count_reg == $past(reload_latch_reg))
        else $error("timer wrap did not reload and raise the IRQ");

    // With the result register empty the block must take a new word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> item.ready)
        else $error("item channel stalled with an empty result register");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the cartridge bank mapper against a cycle-free model of its mapping
// and IRQ timer. CPU write and tick words go in through the item channel, and
// every mapping word that comes out is compared with the model's prediction.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_GAP     = 19;
    localparam int QUIET_LIMIT = 400;
    localparam int DRAIN_CYCLES = 10;
    localparam int SHOWN_MISMATCHES = 10;

    logic clk;
    logic rst_n;

    cbm_in_if  item_ch ();
    cbm_out_if result_ch ();

    cartridge_bank_mapper_irq dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // Mapper state as the model sees it.
    logic [15:0] latch_model;
    logic [15:0] count_model;
    logic [2:0]  ctrl_model;
    logic        irq_model;
    logic [3:0]  prg_sel_model;
    logic [4:0]  prg_model [cbm_pkg::PRG_REGS];
    logic [7:0]  chr_model [cbm_pkg::CHR_REGS];
    logic        mirror_model;

    cbm_pkg::out_word_t expected_mappings [$];
    int        words_sent;
    int        mismatch_count;
    int        quiet_cycles;
    bit        gaps_on;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic cbm_pkg::out_word_t next_mapping(cbm_pkg::in_word_t w);
        logic [3:0]  sel;
        logic [11:0] off;
        logic [3:0]  nib;
        logic [1:0]  low_idx;
        cbm_pkg::out_word_t r;
        sel = w.cpu_address[15:12];
        off = w.cpu_address[11:0];
        nib = w.write_data[3:0];
        low_idx = prg_sel_model[1:0] - 2'd1;
        if (w.opcode == cbm_pkg::OP_TICK)
        begin
            if (ctrl_model[1])
            begin
                if (count_model == cbm_pkg::COUNT_LAST)
                begin
                    count_model = latch_model;
                    irq_model   = 1'b1;
                end
                else
                begin
                    count_model = count_model + 16'd1;
                end
            end
        end
        else
        begin
            case (sel)
                cbm_pkg::SEL_LATCH0: latch_model[3:0]   = nib;
                cbm_pkg::SEL_LATCH1: latch_model[7:4]   = nib;
                cbm_pkg::SEL_LATCH2: latch_model[11:8]  = nib;
                cbm_pkg::SEL_LATCH3: latch_model[15:12] = nib;
                cbm_pkg::SEL_CONTROL:
                begin
                    ctrl_model = w.write_data[2:0];
                    if (ctrl_model[1])
                        count_model = latch_model;
                    irq_model = 1'b0;
                end
                cbm_pkg::SEL_ACK:
                begin
                    ctrl_model[1] = ctrl_model[0];
                    irq_model     = 1'b0;
                end
                cbm_pkg::SEL_PRG_SEL: prg_sel_model = nib;
                cbm_pkg::SEL_BANK:
                begin
                    // The selected register takes the low nibble first, then
                    // the region decode may touch bit 4 of any one of them.
                    if (prg_sel_model != 4'd0 && prg_sel_model <= cbm_pkg::PRG_REGS)
                        prg_model[low_idx][3:0] = nib;
                    case (off[11:10])
                        cbm_pkg::REGION_PRG_HI: prg_model[off[1:0]][4] = w.write_data[4];
                        cbm_pkg::REGION_MIRROR: mirror_model = w.write_data[0];
                        cbm_pkg::REGION_CHR:    chr_model[off[2:0]] = w.write_data;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        r.irq_pending     = irq_model;
        r.prg_bank_8000   = prg_model[0];
        r.prg_bank_a000   = prg_model[1];
        r.prg_bank_c000   = prg_model[2];
        r.mirror_vertical = mirror_model;
        r.chr_banks_lower = {chr_model[3], chr_model[2], chr_model[1], chr_model[0]};
        r.chr_banks_upper = {chr_model[7], chr_model[6], chr_model[5], chr_model[4]};
        return r;
    endfunction

    // The valid line is left high after a word is taken, so a word that
    // follows with no gap keeps it high without a glitch.
    task automatic send_word(cbm_pkg::in_word_t w);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
        end
        @(negedge clk);
        item_ch.valid   <= 1'b1;
        item_ch.payload <= w;
        do
            @(posedge clk);
        while (!item_ch.ready);
        expected_mappings.push_back(next_mapping(w));
        words_sent++;
    endtask

    task automatic cpu_write(logic [3:0] sel, logic [11:0] off, logic [7:0] data);
        cbm_pkg::in_word_t w;
        w.opcode      = cbm_pkg::OP_WRITE;
        w.cpu_address = {sel, off};
        w.write_data  = data;
        send_word(w);
    endtask

    // Address and data are don't-care on a tick, so they carry noise.
    task automatic cpu_tick();
        cbm_pkg::in_word_t w;
        w.opcode      = cbm_pkg::OP_TICK;
        w.cpu_address = 16'($urandom_range(0, 65535));
        w.write_data  = 8'($urandom_range(0, 255));
        send_word(w);
    endtask

    task automatic send_bank_noise();
        int data;
        if ($urandom_range(0, 3) == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                data = ($urandom_range(0, 15) << 4) | $urandom_range(1, cbm_pkg::PRG_REGS);
            else
                data = $urandom_range(0, 255);
            cpu_write(cbm_pkg::SEL_PRG_SEL, 12'($urandom_range(0, 4095)), 8'(data));
        end
        else
        begin
            cpu_write(cbm_pkg::SEL_BANK, 12'($urandom_range(0, 4095)),
                      8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_reset_and_ignored();
        cpu_tick();
        cpu_write(4'h7, 12'hFFF, 8'hFF);
        cpu_write(4'h0, 12'h000, 8'h00);
        cpu_write(4'h6, 12'h000, 8'hFF);
    endtask

    task automatic test_timer_directed();
        cpu_write(cbm_pkg::SEL_LATCH0, 12'hFFF, 8'hFC);
        cpu_write(cbm_pkg::SEL_LATCH1, 12'h000, 8'hFF);
        cpu_write(cbm_pkg::SEL_LATCH2, 12'h123, 8'hFF);
        cpu_write(cbm_pkg::SEL_LATCH3, 12'hABC, 8'hFF);
        // Reload to 0xFFFC; the fourth tick reaches the end and raises the IRQ.
        cpu_write(cbm_pkg::SEL_CONTROL, 12'h000, 8'hFA);
        repeat (5) cpu_tick();
        // Bit 0 is clear, so the acknowledge also stops the timer.
        cpu_write(cbm_pkg::SEL_ACK, 12'h000, 8'hFF);
        cpu_tick();
        cpu_write(cbm_pkg::SEL_CONTROL, 12'hFFF, 8'h05);
        cpu_tick();
        cpu_write(cbm_pkg::SEL_ACK, 12'hFFF, 8'h00);
        cpu_tick();
    endtask

    task automatic test_banks_directed();
        cpu_write(cbm_pkg::SEL_PRG_SEL, 12'h000, 8'hF1);
        cpu_write(cbm_pkg::SEL_BANK, {cbm_pkg::REGION_PRG_HI, 10'h000}, 8'hFF);
        cpu_write(cbm_pkg::SEL_PRG_SEL, 12'hFFF, 8'h04);
        cpu_write(cbm_pkg::SEL_BANK, {cbm_pkg::REGION_MIRROR, 10'h003}, 8'h1F);
        cpu_write(cbm_pkg::SEL_PRG_SEL, 12'h000, 8'h00);
        cpu_write(cbm_pkg::SEL_BANK, {cbm_pkg::REGION_CHR, 10'h3FF}, 8'hFF);
        cpu_write(cbm_pkg::SEL_BANK, {2'b01, 10'h3FF}, 8'hFF);
        cpu_write(cbm_pkg::SEL_BANK, {cbm_pkg::REGION_CHR, 10'h000}, 8'hA5);
        cpu_write(cbm_pkg::SEL_BANK, {cbm_pkg::REGION_PRG_HI, 10'h002}, 8'h10);
        cpu_write(cbm_pkg::SEL_PRG_SEL, 12'h000, 8'h0F);
        cpu_write(cbm_pkg::SEL_BANK, {cbm_pkg::REGION_MIRROR, 10'h001}, 8'h00);
        cpu_write(cbm_pkg::SEL_PRG_SEL, 12'h000, 8'h05);
        cpu_write(cbm_pkg::SEL_BANK, {cbm_pkg::REGION_CHR, 10'h004}, 8'h00);
    endtask

    // Latch values near the top of the count keep the IRQ firing often.
    task automatic test_timer_random(int count);
        int stop_at;
        int data;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            cpu_write(cbm_pkg::SEL_LATCH0, 12'($urandom_range(0, 4095)),
                      8'($urandom_range(0, 255)));
            data = ($urandom_range(0, 15) << 4) | $urandom_range(12, 15);
            cpu_write(cbm_pkg::SEL_LATCH1, 12'($urandom_range(0, 4095)), 8'(data));
            repeat (2)
            begin
                data = ($urandom_range(0, 15) << 4) |
                       (($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 15);
                cpu_write(($urandom_range(0, 1) != 0) ? cbm_pkg::SEL_LATCH2
                                                      : cbm_pkg::SEL_LATCH3,
                          12'($urandom_range(0, 4095)), 8'(data));
            end
            data = $urandom_range(0, 255);
            if ($urandom_range(0, 3) != 0)
                data = data | 2;
            cpu_write(cbm_pkg::SEL_CONTROL, 12'($urandom_range(0, 4095)), 8'(data));
            repeat ($urandom_range(10, 150))
            begin
                case ($urandom_range(0, 15))
                    0: send_bank_noise();
                    1: cpu_write(cbm_pkg::SEL_ACK, 12'($urandom_range(0, 4095)),
                                 8'($urandom_range(0, 255)));
                    default: cpu_tick();
                endcase
            end
        end
    endtask

    task automatic test_banks_random(int count);
        int stop_at;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 63) == 0)
                gaps_on = ~gaps_on;
            case ($urandom_range(0, 9))
                0: cpu_tick();
                1: cpu_write(4'($urandom_range(0, 7)), 12'($urandom_range(0, 4095)),
                             8'($urandom_range(0, 255)));
                default: send_bank_noise();
            endcase
        end
    endtask

    task automatic test_noise(int count);
        cbm_pkg::in_word_t w;
        gaps_on = 1'b1;
        repeat (count)
        begin
            w.opcode      = 1'($urandom_range(0, 1));
            w.cpu_address = 16'($urandom_range(0, 65535));
            w.write_data  = 8'($urandom_range(0, 255));
            send_word(w);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        latch_model     = '0;
        count_model     = '0;
        ctrl_model      = '0;
        irq_model       = 1'b0;
        prg_sel_model   = '0;
        mirror_model    = 1'b0;
        for (int i = 0; i < cbm_pkg::PRG_REGS; i++)
            prg_model[i] = '0;
        for (int i = 0; i < cbm_pkg::CHR_REGS; i++)
            chr_model[i] = '0;
        words_sent     = 0;
        mismatch_count = 0;
        gaps_on        = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_and_ignored();
        test_timer_directed();
        test_banks_directed();
        test_timer_random(750);
        test_banks_random(450);
        test_noise(200);

        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (expected_mappings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Receiver: while gaps are on, each word waits out a random stall before ready goes high.
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            repeat (stall)
            begin
                @(negedge clk);
                result_ch.ready <= 1'b0;
            end
            @(negedge clk);
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
        end
    end

    function automatic bit field_ok(string name, logic [31:0] exp_v, logic [31:0] act_v,
                                    bit verbose);
        if (exp_v !== act_v && verbose)
            $display("  %s: expected %h, got %h", name, exp_v, act_v);
        return exp_v === act_v;
    endfunction

    always @(posedge clk)
    begin
        cbm_pkg::out_word_t exp_w;
        cbm_pkg::out_word_t got;
        bit        ok;
        bit        verbose;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got     = result_ch.payload;
            verbose = (mismatch_count < SHOWN_MISMATCHES);
            if (expected_mappings.size() == 0)
            begin
                if (verbose)
                    $display("unexpected result word at %0t", $realtime);
                mismatch_count++;
            end
            else
            begin
                exp_w = expected_mappings.pop_front();
                if (got !== exp_w && verbose)
                    $display("result word mismatch at %0t", $realtime);
                ok = 1'b1;
                ok &= field_ok("irq_pending", 32'(exp_w.irq_pending),
                               32'(got.irq_pending), verbose);
                ok &= field_ok("prg_bank_8000", 32'(exp_w.prg_bank_8000),
                               32'(got.prg_bank_8000), verbose);
                ok &= field_ok("prg_bank_a000", 32'(exp_w.prg_bank_a000),
                               32'(got.prg_bank_a000), verbose);
                ok &= field_ok("prg_bank_c000", 32'(exp_w.prg_bank_c000),
                               32'(got.prg_bank_c000), verbose);
                ok &= field_ok("mirror_vertical", 32'(exp_w.mirror_vertical),
                               32'(got.mirror_vertical), verbose);
                ok &= field_ok("chr_banks_lower", exp_w.chr_banks_lower,
                               got.chr_banks_lower, verbose);
                ok &= field_ok("chr_banks_upper", exp_w.chr_banks_upper,
                               got.chr_banks_upper, verbose);
                if (!ok)
                    mismatch_count++;
            end
        end
    end

    // A stuck handshake on both channels ends the run.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((item_ch.valid && item_ch.ready) ||
                 (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
